// ===== design/nnsba_pkg.sv =====
// shared constants and types for the nearest-neighbor blit address generator
package nnsba_pkg;

	// image geometry
	localparam int SRC_COLS   = 160;
	localparam int SRC_ROWS   = 144;
	localparam int DST_WIDTH  = 1024;
	localparam int DST_HEIGHT = 1024;

	// field widths
	localparam int REG_W  = 13;
	localparam int PIX_W  = 10;
	localparam int SIDX_W = 15;
	localparam int DIDX_W = 20;

	// signed working width for rectangle arithmetic
	localparam int W_S = REG_W + 2;
	// unsigned width of a normalized destination size or clip bound
	localparam int DN_W = REG_W;
	// offset inside the destination rectangle is below its size
	localparam int REL_W = REG_W - 1;
	// source coordinates, sizes and quotients do not exceed the larger image side
	localparam int SRC_MAX = (SRC_COLS > SRC_ROWS) ? SRC_COLS : SRC_ROWS;
	localparam int Q_W = $clog2(SRC_MAX + 1);
	localparam int PROD_W = REL_W + Q_W;

	// settle count that holds off requests after reset or a register write while the derived geometry is recomputed
	localparam int SETTLE_W = 2;
	localparam logic [SETTLE_W-1:0] SETTLE = SETTLE_W'(2);

	// register map
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_X = 3'd0,
		REG_SRC_Y = 3'd1,
		REG_SRC_W = 3'd2,
		REG_SRC_H = 3'd3,
		REG_DST_X = 3'd4,
		REG_DST_Y = 3'd5,
		REG_DST_W = 3'd6,
		REG_DST_H = 3'd7
	} cfg_reg_t;

	// register reset values
	localparam logic signed [REG_W-1:0] RST_SRC_X = 13'sd0;
	localparam logic signed [REG_W-1:0] RST_SRC_Y = 13'sd0;
	localparam logic signed [REG_W-1:0] RST_SRC_W = 13'sd160;
	localparam logic signed [REG_W-1:0] RST_SRC_H = 13'sd144;
	localparam logic signed [REG_W-1:0] RST_DST_X = 13'sd0;
	localparam logic signed [REG_W-1:0] RST_DST_Y = 13'sd0;
	localparam logic signed [REG_W-1:0] RST_DST_W = 13'sd160;
	localparam logic signed [REG_W-1:0] RST_DST_H = 13'sd144;

	// clamped and clipped geometry of one axis
	typedef struct packed {
		logic                   ok;
		logic [Q_W-1:0]         s0;
		logic [Q_W-1:0]         sn;
		logic signed [W_S-1:0]  d0;
		logic [DN_W-1:0]        dn;
		logic [DN_W-1:0]        lo;
		logic [DN_W-1:0]        hi;
	} axis_t;

	typedef struct packed {
		axis_t x;
		axis_t y;
	} geom_t;

endpackage

// ===== design/nnsba_setup.sv =====
// configuration registers and derived clip geometry
module nnsba_setup (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [nnsba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [nnsba_pkg::REG_W-1:0]        cfg_data,
	output nnsba_pkg::geom_t                   geom,
	output logic                               busy
);

	localparam int W_S = nnsba_pkg::W_S;
	localparam int REG_W = nnsba_pkg::REG_W;
	localparam int DN_W = nnsba_pkg::DN_W;
	localparam int Q_W = nnsba_pkg::Q_W;
	localparam logic signed [W_S-1:0] SL_X = W_S'(nnsba_pkg::SRC_COLS);
	localparam logic signed [W_S-1:0] SL_Y = W_S'(nnsba_pkg::SRC_ROWS);
	localparam logic signed [W_S-1:0] DL_X = W_S'(nnsba_pkg::DST_WIDTH);
	localparam logic signed [W_S-1:0] DL_Y = W_S'(nnsba_pkg::DST_HEIGHT);

	// first half of the axis setup
	typedef struct packed {
		logic                  s_pos;
		logic signed [W_S-1:0] s0c;
		logic signed [W_S-1:0] sn;
		logic signed [W_S-1:0] s_end;
		logic signed [W_S-1:0] d0n;
		logic signed [W_S-1:0] dnn;
		logic signed [W_S-1:0] d_end;
	} pre_t;

	logic signed [REG_W-1:0] src_x_q, src_y_q, src_w_q, src_h_q;
	logic signed [REG_W-1:0] dst_x_q, dst_y_q, dst_w_q, dst_h_q;
	pre_t pre_x_q, pre_y_q;
	nnsba_pkg::geom_t geom_q;
	logic [nnsba_pkg::SETTLE_W-1:0] settle_q;

	// flip negative destination size, clamp source corner
	function automatic pre_t axis_pre(input logic signed [REG_W-1:0] s0,
	                                  input logic signed [REG_W-1:0] sn,
	                                  input logic signed [REG_W-1:0] d0,
	                                  input logic signed [REG_W-1:0] dn);
		pre_t p;
		logic signed [W_S-1:0] s0w, snw, d0w, dnw, s0c;
		s0w = W_S'(s0);
		snw = W_S'(sn);
		d0w = W_S'(d0);
		dnw = W_S'(dn);
		s0c = (s0w < 0) ? '0 : s0w;
		p.s_pos = (snw > 0);
		p.s0c = s0c;
		p.sn = snw;
		p.s_end = s0c + snw;
		p.d0n = (dnw < 0) ? d0w + dnw : d0w;
		p.dnn = (dnw < 0) ? -dnw : dnw;
		p.d_end = (dnw < 0) ? d0w : d0w + dnw;
		return p;
	endfunction

	// cut source size to the image, clip destination to the framebuffer
	function automatic nnsba_pkg::axis_t axis_fin(input pre_t p,
	                                              input logic signed [W_S-1:0] sl,
	                                              input logic signed [W_S-1:0] dl);
		nnsba_pkg::axis_t a;
		logic signed [W_S-1:0] sn_cut, s0c, d0n, dnn, d_end;
		s0c = p.s0c;
		d0n = p.d0n;
		dnn = p.dnn;
		d_end = p.d_end;
		sn_cut = (p.s_end > sl) ? sl - s0c : p.sn;
		a.ok = p.s_pos && (sn_cut > 0) && (dnn > 0) && (d0n < dl) && (d_end > 0);
		a.s0 = s0c[Q_W-1:0];
		a.sn = sn_cut[Q_W-1:0];
		a.d0 = d0n;
		a.dn = dnn[DN_W-1:0];
		a.lo = (d0n > 0) ? d0n[DN_W-1:0] : '0;
		a.hi = (d_end < dl) ? d_end[DN_W-1:0] : dl[DN_W-1:0];
		return a;
	endfunction

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_x_q <= nnsba_pkg::RST_SRC_X;
			src_y_q <= nnsba_pkg::RST_SRC_Y;
			src_w_q <= nnsba_pkg::RST_SRC_W;
			src_h_q <= nnsba_pkg::RST_SRC_H;
			dst_x_q <= nnsba_pkg::RST_DST_X;
			dst_y_q <= nnsba_pkg::RST_DST_Y;
			dst_w_q <= nnsba_pkg::RST_DST_W;
			dst_h_q <= nnsba_pkg::RST_DST_H;
		end else if (cfg_wr_en) begin
			case (nnsba_pkg::cfg_reg_t'(cfg_index))
				nnsba_pkg::REG_SRC_X: src_x_q <= cfg_data;
				nnsba_pkg::REG_SRC_Y: src_y_q <= cfg_data;
				nnsba_pkg::REG_SRC_W: src_w_q <= cfg_data;
				nnsba_pkg::REG_SRC_H: src_h_q <= cfg_data;
				nnsba_pkg::REG_DST_X: dst_x_q <= cfg_data;
				nnsba_pkg::REG_DST_Y: dst_y_q <= cfg_data;
				nnsba_pkg::REG_DST_W: dst_w_q <= cfg_data;
				nnsba_pkg::REG_DST_H: dst_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// settle counter holds off requests until geometry is current
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= nnsba_pkg::SETTLE;
		end else if (cfg_wr_en) begin
			settle_q <= nnsba_pkg::SETTLE;
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	// two-step geometry derivation
	always_ff @(posedge clk) begin
		pre_x_q <= axis_pre(src_x_q, src_w_q, dst_x_q, dst_w_q);
		pre_y_q <= axis_pre(src_y_q, src_h_q, dst_y_q, dst_h_q);
		geom_q.x <= axis_fin(pre_x_q, SL_X, DL_X);
		geom_q.y <= axis_fin(pre_y_q, SL_Y, DL_Y);
	end

	assign geom = geom_q;
	assign busy = (settle_q != '0);

endmodule

// ===== design/nnsba_datapath.sv =====
// per-pixel address pipeline: clip test, scale multiply, pipelined divider, index math
module nnsba_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  nnsba_pkg::geom_t                 geom,
	input  logic                             busy,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [nnsba_pkg::PIX_W-1:0]      pixel_col,
	input  logic [nnsba_pkg::PIX_W-1:0]      pixel_row,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             write_enable,
	output logic [nnsba_pkg::SIDX_W-1:0]     source_index,
	output logic [nnsba_pkg::DIDX_W-1:0]     target_index
);

	localparam int W_S = nnsba_pkg::W_S;
	localparam int DN_W = nnsba_pkg::DN_W;
	localparam int REL_W = nnsba_pkg::REL_W;
	localparam int Q_W = nnsba_pkg::Q_W;
	localparam int PROD_W = nnsba_pkg::PROD_W;
	localparam int SIDX_W = nnsba_pkg::SIDX_W;
	localparam int DIDX_W = nnsba_pkg::DIDX_W;
	// stage slots: s1, s2, divider steps, s4, s5
	localparam int NST = Q_W + 4;
	localparam int ST_S2 = 1;
	localparam int ST_DIV = 2;
	localparam int ST_S4 = Q_W + 2;
	localparam int ST_S5 = Q_W + 3;

	typedef struct packed {
		logic              we;
		logic [REL_W-1:0]  rel_x;
		logic [REL_W-1:0]  rel_y;
		logic [DIDX_W-1:0] didx;
	} front_t;

	typedef struct packed {
		logic              we;
		logic [PROD_W-1:0] rem_x;
		logic [PROD_W-1:0] rem_y;
		logic [Q_W-1:0]    quo_x;
		logic [Q_W-1:0]    quo_y;
		logic [DIDX_W-1:0] didx;
	} div_t;

	typedef struct packed {
		logic              we;
		logic [Q_W:0]      scol;
		logic [Q_W:0]      srow;
		logic [DIDX_W-1:0] didx;
	} map_t;

	logic [NST-1:0] vld_q;
	logic [NST-1:0] adv;
	logic           in_fire;

	front_t front_d, front_s1;
	div_t   mul_s2;
	div_t   div_src [Q_W];
	div_t   div_nxt [Q_W];
	div_t   div_s3  [Q_W];
	map_t   map_s4;
	logic [31:0]       sidx_full;
	logic              we_s5;
	logic [SIDX_W-1:0] sidx_s5;
	logic [DIDX_W-1:0] didx_s5;

	// a stage moves when it is empty or the one after it moves
	always_comb begin
		adv[NST-1] = !vld_q[NST-1] || out_ready;
		for (int i = NST - 2; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	assign in_ready = adv[0] && !busy;
	assign in_fire = in_valid && in_ready;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_fire;
			end
			for (int i = 1; i < NST; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// s1: clip test, offsets from the destination corner, target index
	always_comb begin
		logic signed [W_S-1:0] col_s, row_s, rx, ry;
		logic [DN_W-1:0]       col_u, row_u;
		logic                  in_x, in_y;
		logic [31:0]           didx_full;
		col_s = W_S'(pixel_col);
		row_s = W_S'(pixel_row);
		col_u = DN_W'(pixel_col);
		row_u = DN_W'(pixel_row);
		in_x = (col_u >= geom.x.lo) && (col_u < geom.x.hi);
		in_y = (row_u >= geom.y.lo) && (row_u < geom.y.hi);
		rx = col_s - geom.x.d0;
		ry = row_s - geom.y.d0;
		didx_full = 32'(pixel_row) * 32'(nnsba_pkg::DST_WIDTH) + 32'(pixel_col);
		front_d.we = geom.x.ok && geom.y.ok && in_x && in_y;
		front_d.rel_x = rx[REL_W-1:0];
		front_d.rel_y = ry[REL_W-1:0];
		front_d.didx = front_d.we ? didx_full[DIDX_W-1:0] : '0;
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			front_s1 <= front_d;
		end
	end

	// s2: offset times source size
	always_ff @(posedge clk) begin
		if (adv[ST_S2]) begin
			mul_s2.we <= front_s1.we;
			mul_s2.rem_x <= PROD_W'(front_s1.rel_x) * PROD_W'(geom.x.sn);
			mul_s2.rem_y <= PROD_W'(front_s1.rel_y) * PROD_W'(geom.y.sn);
			mul_s2.quo_x <= '0;
			mul_s2.quo_y <= '0;
			mul_s2.didx <= front_s1.didx;
		end
	end

	// s3: restoring divide by destination size, one quotient bit per stage
	always_comb begin
		int b;
		div_src[0] = mul_s2;
		for (int k = 1; k < Q_W; k++) begin
			div_src[k] = div_s3[k-1];
		end
		for (int k = 0; k < Q_W; k++) begin
			b = Q_W - 1 - k;
			div_nxt[k] = div_src[k];
			if ((div_src[k].rem_x >> b) >= PROD_W'(geom.x.dn)) begin
				div_nxt[k].rem_x = div_src[k].rem_x - (PROD_W'(geom.x.dn) << b);
				div_nxt[k].quo_x[b] = 1'b1;
			end
			if ((div_src[k].rem_y >> b) >= PROD_W'(geom.y.dn)) begin
				div_nxt[k].rem_y = div_src[k].rem_y - (PROD_W'(geom.y.dn) << b);
				div_nxt[k].quo_y[b] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < Q_W; k++) begin
			if (adv[ST_DIV+k]) begin
				div_s3[k] <= div_nxt[k];
			end
		end
	end

	// s4: add source corner to the scaled offsets
	always_ff @(posedge clk) begin
		if (adv[ST_S4]) begin
			map_s4.we <= div_s3[Q_W-1].we;
			map_s4.scol <= (Q_W+1)'(geom.x.s0) + (Q_W+1)'(div_s3[Q_W-1].quo_x);
			map_s4.srow <= (Q_W+1)'(geom.y.s0) + (Q_W+1)'(div_s3[Q_W-1].quo_y);
			map_s4.didx <= div_s3[Q_W-1].didx;
		end
	end

	// s5: linear source index, output register
	assign sidx_full = 32'(map_s4.srow) * 32'(nnsba_pkg::SRC_COLS) + 32'(map_s4.scol);

	always_ff @(posedge clk) begin
		if (adv[ST_S5]) begin
			we_s5 <= map_s4.we;
			sidx_s5 <= map_s4.we ? sidx_full[SIDX_W-1:0] : '0;
			didx_s5 <= map_s4.didx;
		end
	end

	assign out_valid = vld_q[NST-1];
	assign write_enable = we_s5;
	assign source_index = sidx_s5;
	assign target_index = didx_s5;

endmodule

// ===== design/nearest_neighbor_scaled_blit_address_top.sv =====
// Nearest-neighbor scaled blit address generator, top level.
// Stages: two front stages, one divider stage per quotient bit, here 8, then two index
// stages. Throughput: one request per cycle while out_ready is high and busy is low;
// the divider is fully pipelined.
// Reset: registers take their defaults; requests are held off after reset and after every
// register write while the clip geometry is recomputed.
module nearest_neighbor_scaled_blit_address_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [nnsba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nnsba_pkg::REG_W-1:0]      cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [nnsba_pkg::PIX_W-1:0]      pixel_col,
	input  logic [nnsba_pkg::PIX_W-1:0]      pixel_row,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             write_enable,
	output logic [nnsba_pkg::SIDX_W-1:0]     source_index,
	output logic [nnsba_pkg::DIDX_W-1:0]     target_index
);

	nnsba_pkg::geom_t geom;
	logic             busy;

	// registers and derived geometry
	nnsba_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom),
		.busy      (busy)
	);

	// per-pixel pipeline
	nnsba_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.geom         (geom),
		.busy         (busy),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_col    (pixel_col),
		.pixel_row    (pixel_row),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.write_enable (write_enable),
		.source_index (source_index),
		.target_index (target_index)
	);

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the nearest-neighbor scaled blit address generator
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REG_W        = nnsba_pkg::REG_W;
	localparam int PIX_W        = nnsba_pkg::PIX_W;
	localparam int SIDX_W       = nnsba_pkg::SIDX_W;
	localparam int DIDX_W       = nnsba_pkg::DIDX_W;
	localparam int SRC_COLS     = nnsba_pkg::SRC_COLS;
	localparam int SRC_ROWS     = nnsba_pkg::SRC_ROWS;
	localparam int DST_WIDTH    = nnsba_pkg::DST_WIDTH;
	localparam int DST_HEIGHT   = nnsba_pkg::DST_HEIGHT;
	localparam int PIPE_LATENCY = 11;
	localparam int CYCLE_LIMIT  = 500_000;
	localparam int PIX_MAX      = (1 << PIX_W) - 1;

	// one expected address result, tagged with the pixel that caused it
	typedef struct packed {
		logic              we;
		logic [SIDX_W-1:0] sidx;
		logic [DIDX_W-1:0] tidx;
		logic [PIX_W-1:0]  col;
		logic [PIX_W-1:0]  row;
	} blit_expect_t;

	// register shadow, clip geometry and the queue of pending address results
	class blit_scoreboard;
		logic signed [REG_W-1:0] regs [8];
		bit area_ok;
		int scol0, scols, dcol0, dcols, col_lo, col_hi;
		int srow0, srows, drow0, drows, row_lo, row_hi;
		blit_expect_t expected_q [$];
		int errors;

		function new();
			regs[nnsba_pkg::REG_SRC_X] = nnsba_pkg::RST_SRC_X;
			regs[nnsba_pkg::REG_SRC_Y] = nnsba_pkg::RST_SRC_Y;
			regs[nnsba_pkg::REG_SRC_W] = nnsba_pkg::RST_SRC_W;
			regs[nnsba_pkg::REG_SRC_H] = nnsba_pkg::RST_SRC_H;
			regs[nnsba_pkg::REG_DST_X] = nnsba_pkg::RST_DST_X;
			regs[nnsba_pkg::REG_DST_Y] = nnsba_pkg::RST_DST_Y;
			regs[nnsba_pkg::REG_DST_W] = nnsba_pkg::RST_DST_W;
			regs[nnsba_pkg::REG_DST_H] = nnsba_pkg::RST_DST_H;
			errors = 0;
			update_geometry();
		endfunction

		// clamp the source span and normalize and clip the destination span of one axis
		function bit clip_axis(int s0, int sn, int slimit, int d0, int dn, int dlimit,
				output int so, output int sno, output int dorg, output int dno,
				output int lo, output int hi);
			so = 0;
			sno = 0;
			dorg = 0;
			dno = 0;
			lo = 0;
			hi = 0;
			if (sn <= 0)
				return 1'b0;
			if (dn < 0) begin
				d0 += dn;
				dn = -dn;
			end
			if (s0 < 0)
				s0 = 0;
			if (s0 + sn > slimit)
				sn = slimit - s0;
			if (sn <= 0)
				return 1'b0;
			if (dn <= 0 || d0 >= dlimit || d0 + dn <= 0)
				return 1'b0;
			so = s0;
			sno = sn;
			dorg = d0;
			dno = dn;
			lo = (d0 > 0) ? d0 : 0;
			hi = (d0 + dn < dlimit) ? d0 + dn : dlimit;
			return 1'b1;
		endfunction

		function void update_geometry();
			area_ok = clip_axis(int'(regs[nnsba_pkg::REG_SRC_X]),
					int'(regs[nnsba_pkg::REG_SRC_W]), SRC_COLS,
					int'(regs[nnsba_pkg::REG_DST_X]),
					int'(regs[nnsba_pkg::REG_DST_W]), DST_WIDTH,
					scol0, scols, dcol0, dcols, col_lo, col_hi)
				&& clip_axis(int'(regs[nnsba_pkg::REG_SRC_Y]),
					int'(regs[nnsba_pkg::REG_SRC_H]), SRC_ROWS,
					int'(regs[nnsba_pkg::REG_DST_Y]),
					int'(regs[nnsba_pkg::REG_DST_H]), DST_HEIGHT,
					srow0, srows, drow0, drows, row_lo, row_hi);
		endfunction

		function void set_reg(nnsba_pkg::cfg_reg_t idx, logic signed [REG_W-1:0] v);
			regs[idx] = v;
			update_geometry();
		endfunction

		// scaled source address and linear target address of one framebuffer pixel
		function blit_expect_t map_pixel(int col, int row);
			blit_expect_t e;
			int scol, srow;
			e = '0;
			e.col = PIX_W'(col);
			e.row = PIX_W'(row);
			if (!area_ok || col < col_lo || col >= col_hi || row < row_lo || row >= row_hi)
				return e;
			scol = scol0 + ((col - dcol0) * scols) / dcols;
			srow = srow0 + ((row - drow0) * srows) / drows;
			e.we = 1'b1;
			e.sidx = SIDX_W'(srow * SRC_COLS + scol);
			e.tidx = DIDX_W'(row * DST_WIDTH + col);
			return e;
		endfunction

		function void note_request(int col, int row);
			expected_q.push_back(map_pixel(col, row));
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic we, logic [SIDX_W-1:0] sidx, logic [DIDX_W-1:0] tidx);
			blit_expect_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("result with no request pending (we %b src %0d tgt %0d)",
					we, sidx, tidx));
				return;
			end
			e = expected_q.pop_front();
			if (we !== e.we)
				report($sformatf("pixel (%0d,%0d) write_enable got %b expected %b",
					e.col, e.row, we, e.we));
			if (sidx !== e.sidx)
				report($sformatf("pixel (%0d,%0d) source_index got %0d expected %0d",
					e.col, e.row, sidx, e.sidx));
			if (tidx !== e.tidx)
				report($sformatf("pixel (%0d,%0d) target_index got %0d expected %0d",
					e.col, e.row, tidx, e.tidx));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	nnsba_pkg::cfg_reg_t cfg_index = nnsba_pkg::REG_SRC_X;
	logic [REG_W-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [PIX_W-1:0]    pixel_col = '0;
	logic [PIX_W-1:0]    pixel_row = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                write_enable;
	logic [SIDX_W-1:0]   source_index;
	logic [DIDX_W-1:0]   target_index;

	blit_scoreboard sb;
	bit no_idle = 1'b0;
	int ready_hold = 0;
	int cycle_count = 0;

	nearest_neighbor_scaled_blit_address_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_col    (pixel_col),
		.pixel_row    (pixel_row),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.write_enable (write_enable),
		.source_index (source_index),
		.target_index (target_index)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL nearest_neighbor_scaled_blit_address_top");
		$finish;
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side: check accepted results, stall at random
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready)
			sb.check_result(write_enable, source_index, target_index);
		if (ready_hold > 0) begin
			ready_hold--;
			out_ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 7) == 0) begin
			ready_hold = pick_gap();
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// drop valid and wait until every pending result has come back
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	// write all eight geometry registers once the block is idle
	task automatic program_geometry(int sx, int sy, int sw, int sh,
			int dx, int dy, int dw, int dh);
		logic signed [REG_W-1:0] vals [8];
		vals[nnsba_pkg::REG_SRC_X] = REG_W'(sx);
		vals[nnsba_pkg::REG_SRC_Y] = REG_W'(sy);
		vals[nnsba_pkg::REG_SRC_W] = REG_W'(sw);
		vals[nnsba_pkg::REG_SRC_H] = REG_W'(sh);
		vals[nnsba_pkg::REG_DST_X] = REG_W'(dx);
		vals[nnsba_pkg::REG_DST_Y] = REG_W'(dy);
		vals[nnsba_pkg::REG_DST_W] = REG_W'(dw);
		vals[nnsba_pkg::REG_DST_H] = REG_W'(dh);
		settle_idle();
		for (int i = 0; i < 8; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= nnsba_pkg::cfg_reg_t'(i);
			cfg_data <= vals[i];
			sb.set_reg(nnsba_pkg::cfg_reg_t'(i), vals[i]);
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// one pixel request, held until accepted
	task automatic send_pixel(int col, int row);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_col <= PIX_W'(col);
		pixel_row <= PIX_W'(row);
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		sb.note_request(col, row);
	endtask

	function automatic int pick_extreme();
		case ($urandom_range(0, 4))
			0: return -4096;
			1: return 4095;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	// a coordinate just inside or just outside a clip span
	function automatic int near_edge(int lo, int hi);
		int v;
		case ($urandom_range(0, 3))
			0: v = lo - 1;
			1: v = lo;
			2: v = hi - 1;
			default: v = hi;
		endcase
		if (v < 0)
			v = 0;
		if (v > PIX_MAX)
			v = PIX_MAX;
		return v;
	endfunction

	// random geometry: mostly sane rectangles, some raw noise and register extremes
	task automatic random_geometry();
		int mode, sx, sy, sw, sh, dx, dy, dw, dh;
		mode = $urandom_range(0, 9);
		if (mode == 0) begin
			sx = $urandom_range(0, 8191);
			sy = $urandom_range(0, 8191);
			sw = $urandom_range(0, 8191);
			sh = $urandom_range(0, 8191);
			dx = $urandom_range(0, 8191);
			dy = $urandom_range(0, 8191);
			dw = $urandom_range(0, 8191);
			dh = $urandom_range(0, 8191);
		end else if (mode == 1) begin
			sx = pick_extreme();
			sy = pick_extreme();
			sw = pick_extreme();
			sh = pick_extreme();
			dx = pick_extreme();
			dy = pick_extreme();
			dw = pick_extreme();
			dh = pick_extreme();
		end else begin
			sx = int'($urandom_range(0, 179)) - 20;
			sy = int'($urandom_range(0, 163)) - 20;
			sw = $urandom_range(1, 200);
			sh = $urandom_range(1, 180);
			dw = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 1100);
			dh = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 1100);
			dx = int'($urandom_range(0, 1300)) - 200;
			dy = int'($urandom_range(0, 1300)) - 200;
			if ($urandom_range(0, 3) == 0)
				dw = -dw;
			if ($urandom_range(0, 3) == 0)
				dh = -dh;
		end
		program_geometry(sx, sy, sw, sh, dx, dy, dw, dh);
	endtask

	// random pixels, biased into and around the clipped target
	task automatic run_random_phase(int count);
		int r, col, row;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (sb.area_ok && r < 70) begin
				col = $urandom_range(sb.col_lo, sb.col_hi - 1);
				row = $urandom_range(sb.row_lo, sb.row_hi - 1);
			end else if (sb.area_ok && r < 85) begin
				col = near_edge(sb.col_lo, sb.col_hi);
				row = near_edge(sb.row_lo, sb.row_hi);
			end else begin
				col = $urandom_range(0, PIX_MAX);
				row = $urandom_range(0, PIX_MAX);
			end
			send_pixel(col, row);
		end
	endtask

	// stimulus
	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// power-on geometry: one-to-one copy of the full source image
		send_pixel(0, 0);
		send_pixel(159, 143);
		send_pixel(160, 5);
		send_pixel(5, 144);
		send_pixel(1023, 1023);
		send_pixel(1023, 0);
		send_pixel(0, 1023);

		// flipped destination, source corner below zero and size past the image edge
		program_geometry(-5, 130, 4095, 40, 1023, 1023, -1024, -1024);
		send_pixel(0, 0);
		send_pixel(1022, 1022);
		send_pixel(1023, 1023);
		send_pixel(511, 700);

		// source width zero, then source height negative
		program_geometry(0, 0, 0, 144, 0, 0, 160, 144);
		send_pixel(5, 5);
		program_geometry(0, 0, 160, -4096, 0, 0, 160, 144);
		send_pixel(5, 5);

		// source corner past the image leaves an empty source
		program_geometry(200, 0, 10, 144, 0, 0, 160, 144);
		send_pixel(3, 3);

		// zero-size destination, destination right of and left of the framebuffer
		program_geometry(0, 0, 160, 144, 0, 0, 0, 144);
		send_pixel(0, 0);
		program_geometry(0, 0, 160, 144, 1024, 0, 160, 144);
		send_pixel(1023, 0);
		program_geometry(0, 0, 160, 144, -4096, 0, 4095, 144);
		send_pixel(0, 0);

		// every register at its top value, then at its bottom value
		program_geometry(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
		send_pixel(1023, 1023);
		program_geometry(-4096, -4096, -4096, -4096, -4096, -4096, -4096, -4096);
		send_pixel(0, 0);

		// one source pixel stretched past the framebuffer on both axes
		program_geometry(159, 143, 1, 1, -3000, -3000, 4095, 4095);
		send_pixel(0, 0);
		send_pixel(1023, 1023);

		// whole source squeezed into a single target pixel
		program_geometry(0, 0, 160, 144, 1023, 1023, 1, 1);
		send_pixel(1023, 1023);

		// random geometries, some phases without any idling
		for (int p = 0; p < 25; p++) begin
			random_geometry();
			no_idle = ($urandom_range(0, 3) == 0);
			run_random_phase($urandom_range(20, 45));
		end

		no_idle = 1'b0;
		settle_idle();
		repeat (2 * PIPE_LATENCY) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS nearest_neighbor_scaled_blit_address_top");
		else
			$display("FAIL nearest_neighbor_scaled_blit_address_top");
		$finish;
	end

endmodule
